FILE: rtl/core/rbfd_pkg.sv
// Shared types, widths and codes of the ray/box free-distance scanner.
// Depends on nothing; every module under rtl/core imports it.
package rbfd_pkg;

  localparam int BEAMS     = 64;
  localparam int IDX_W     = $clog2(BEAMS);
  localparam int CNT_W     = $clog2(BEAMS + 1);

  localparam int DIST_W    = 31;
  localparam int DIR_W     = 16;
  localparam int CRD_W     = 32;
  localparam int HALF_W    = CRD_W / 2;
  localparam int EPS_W     = 16;
  localparam int BCNT_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;

  localparam int EXT_W     = CRD_W + 1;          // edge vector component
  localparam int SHORT_W   = DIR_W + 1;          // short multiplier operand
  localparam int PROD_W    = EXT_W + SHORT_W;    // product of the shared multiplier
  localparam int DET_W     = 50;                 // determinant and n2, signed
  localparam int MAG_W     = 64;                 // cross products of the t1 numerator
  localparam int FRAC_SH   = 14;                 // Q2.14 direction scale
  localparam int SAT_SH    = DIST_W - FRAC_SH;   // quotient saturates at mag >= d << 17
  localparam int SAT_LIM   = MAG_W - SAT_SH;     // below d = 2^47 the test applies

  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  localparam logic [DIST_W-1:0] MAX_DIST_RST = DIST_W'(6553600);
  localparam logic [EPS_W-1:0]  DET_EPS_RST  = EPS_W'(1074);
  localparam logic [BCNT_W-1:0] BEAM_CNT_RST = BCNT_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_CNT = 2'd2;

  localparam int IN_W  = 296;
  localparam int OUT_W = 40;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RECT  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [DIST_W-1:0] span;
  } edge_res_t;

endpackage

FILE: rtl/core/rbfd_mul.sv
// Shared signed multiplier of the edge engine, output registered.
// Depends on rbfd_pkg.
module rbfd_mul import rbfd_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [EXT_W-1:0]   a_i,
  input  logic signed [SHORT_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/rbfd_div.sv
// Restoring divider, one quotient bit per cycle: floor(mag * 2^14 / den).
// Depends on rbfd_pkg; the caller guarantees the quotient fits in DIST_W bits.
module rbfd_div import rbfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MAG_W-1:0]  mag_i,
  input  logic [DET_W-1:0]  den_i,
  output logic              done_o,
  output logic [DIST_W-1:0] quo_o
);

  localparam int CW = $clog2(DIST_W + 1);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [DET_W-1:0]  rem_q, den_q;
  logic [DIST_W-1:0] num_q, quo_q;
  logic [DET_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, num_q[DIST_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIST_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DET_W'(mag_i[MAG_W-1:SAT_SH]);
      num_q <= {mag_i[SAT_SH-1:0], {FRAC_SH{1'b0}}};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
      num_q <= {num_q[DIST_W-2:0], 1'b0};
      quo_q <= {quo_q[DIST_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/core/rbfd_edge.sv
// Ray/edge test engine: eight products on the shared multiplier, sign and
// range checks, then, unless rejected or saturated, the distance through the
// iterative divider. Depends on rbfd_pkg, rbfd_mul and rbfd_div.
module rbfd_edge import rbfd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic signed [CRD_W-1:0] p1_x_i,
  input  logic signed [CRD_W-1:0] p1_y_i,
  input  logic signed [CRD_W-1:0] p2_x_i,
  input  logic signed [CRD_W-1:0] p2_y_i,
  input  logic [EPS_W-1:0]        eps_i,
  output edge_res_t               res_o
);

  typedef enum logic [2:0] {E_IDLE, E_MUL, E_CHK, E_DEC, E_DIV} state_e;

  state_e                    state_q;
  logic [3:0]                step_q;
  edge_res_t                 res_q;
  logic signed [EXT_W-1:0]   ex_q, ey_q;
  logic signed [CRD_W-1:0]   px_q, py_q;
  logic signed [DIR_W-1:0]   dx_q, dy_q;
  logic signed [DET_W-1:0]   det_q, n2_q, n2a_q;
  logic [MAG_W-1:0]          acc_a_q, acc_b_q, mag_q;
  logic [DET_W-1:0]          d_q;
  logic                      dneg_q, nneg_q;

  logic signed [EXT_W-1:0]   mul_a;
  logic signed [SHORT_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [MAG_W-1:0]          prod64, prod64_sh;
  logic [2:0]                acc_sel;
  logic                      ageb, dneg, reject, sat, div_start, div_done;
  logic [DIST_W-1:0]         quo;

  rbfd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rbfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag_q),
    .den_i   (d_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // operand schedule: det, n2, then the two halves of each t1 cross product
  always_comb begin
    mul_a = ex_q;
    mul_b = SHORT_W'(dy_q);
    case (step_q[2:0])
      3'd0: begin mul_a = ex_q;         mul_b = SHORT_W'(dy_q); end
      3'd1: begin mul_a = ey_q;         mul_b = SHORT_W'(dx_q); end
      3'd2: begin mul_a = EXT_W'(py_q); mul_b = SHORT_W'(dx_q); end
      3'd3: begin mul_a = EXT_W'(px_q); mul_b = SHORT_W'(dy_q); end
      3'd4: begin mul_a = ex_q; mul_b = $signed({1'b0, py_q[HALF_W-1:0]}); end
      3'd5: begin mul_a = ex_q; mul_b = SHORT_W'($signed(py_q[CRD_W-1:HALF_W])); end
      3'd6: begin mul_a = ey_q; mul_b = $signed({1'b0, px_q[HALF_W-1:0]}); end
      3'd7: begin mul_a = ey_q; mul_b = SHORT_W'($signed(px_q[CRD_W-1:HALF_W])); end
      default: begin mul_a = ex_q; mul_b = SHORT_W'(dy_q); end
    endcase
  end

  always_comb begin
    acc_sel   = 3'(step_q - 4'd1);
    prod64    = MAG_W'(prod);
    prod64_sh = prod64 << HALF_W;
    ageb      = $signed(acc_a_q) >= $signed(acc_b_q);
    dneg      = det_q[DET_W-1];
    reject    = (d_q == '0) || (d_q < DET_W'(eps_i)) || n2a_q[DET_W-1] ||
                ($unsigned(n2a_q) > d_q) || ((mag_q != '0) && (nneg_q != dneg_q));
    sat       = (d_q < (DET_W'(1) << SAT_LIM)) &&
                ({{SAT_SH{1'b0}}, mag_q} >= {d_q, {SAT_SH{1'b0}}});
    div_start = (state_q == E_DEC) && !reject && !sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      step_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        E_IDLE: begin
          // the result strobe lasts the one idle cycle after a decision
          res_q.done <= 1'b0;
          if (start_i) begin
            step_q  <= '0;
            state_q <= E_MUL;
          end
        end
        E_MUL: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd8) state_q <= E_CHK;
        end
        E_CHK: state_q <= E_DEC;
        E_DEC: begin
          if (reject) begin
            res_q   <= '{done: 1'b1, hit: 1'b0, span: DIST_SAT};
            state_q <= E_IDLE;
          end else if (sat) begin
            res_q   <= '{done: 1'b1, hit: 1'b1, span: DIST_SAT};
            state_q <= E_IDLE;
          end else begin
            state_q <= E_DIV;
          end
        end
        E_DIV: begin
          if (div_done) begin
            res_q   <= '{done: 1'b1, hit: 1'b1, span: quo};
            state_q <= E_IDLE;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && start_i) begin
      ex_q    <= EXT_W'(p2_x_i) - EXT_W'(p1_x_i);
      ey_q    <= EXT_W'(p2_y_i) - EXT_W'(p1_y_i);
      px_q    <= p1_x_i;
      py_q    <= p1_y_i;
      dx_q    <= dir_x_i;
      dy_q    <= dir_y_i;
      det_q   <= '0;
      n2_q    <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (state_q == E_MUL && step_q != 4'd0) begin
      case (acc_sel)
        3'd0: det_q   <= det_q + DET_W'(prod);
        3'd1: det_q   <= det_q - DET_W'(prod);
        3'd2: n2_q    <= n2_q + DET_W'(prod);
        3'd3: n2_q    <= n2_q - DET_W'(prod);
        3'd4: acc_a_q <= acc_a_q + prod64;
        3'd5: acc_a_q <= acc_a_q + prod64_sh;
        3'd6: acc_b_q <= acc_b_q + prod64;
        3'd7: acc_b_q <= acc_b_q + prod64_sh;
        default: det_q <= det_q;
      endcase
    end else if (state_q == E_CHK) begin
      dneg_q <= dneg;
      d_q    <= dneg ? DET_W'(-det_q) : DET_W'(det_q);
      n2a_q  <= dneg ? -n2_q : n2_q;
      mag_q  <= ageb ? acc_a_q - acc_b_q : acc_b_q - acc_a_q;
      nneg_q <= !ageb;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/core/ray_box_free_distance.sv
// Ray/box free-distance scanner: per-beam direction and free-distance tables.
// Clear and load complete in the idle state; a read passes through ST_READ into the
// registered result. A rectangle scans each active beam: direction read and latch,
// then per edge latch, multiply, check, divide unless rejected or saturated, hand back.
// Reset (rst_ni low, asynchronous) restores the register defaults and marks every
// distance as the free-distance ceiling's default; the direction table holds no reset value.
module ray_box_free_distance import rbfd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // beam_index[5:0], dir_x[21:6], dir_y[37:22], corner0_x[69:38], corner0_y[101:70],
  // corner1_x[133:102], corner1_y[165:134], corner2_x[197:166], corner2_y[229:198],
  // corner3_x[261:230], corner3_y[293:262], zero fill [295:294]
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]           s_axis_tuser_i,
  // master side
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // read_index[5:0], free_distance[36:6], zero fill [39:37]
  output logic [OUT_W-1:0]     m_axis_tdata_o,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int DIR_X_LO = IDX_W;
  localparam int DIR_Y_LO = DIR_X_LO + DIR_W;
  localparam int CRN_LO   = DIR_Y_LO + DIR_W;
  localparam int OUT_PAD  = OUT_W - IDX_W - DIST_W;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_BRD, ST_BLAT, ST_EDGE, ST_BWR} state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        beam_q, n_q;
  logic [1:0]              j_q;
  logic [DIST_W-1:0]       best_q, fill_q;
  logic [DIST_W-1:0]       max_q;
  logic [EPS_W-1:0]        eps_q;
  logic [BCNT_W-1:0]       bcnt_q;
  logic [BEAMS-1:0]        vld_q;
  logic signed [CRD_W-1:0] cx_q [4];
  logic signed [CRD_W-1:0] cy_q [4];
  logic [IDX_W-1:0]        idx_q;
  logic                    m_valid_q;
  logic [IDX_W-1:0]        out_idx_q;
  logic [DIST_W-1:0]       out_dist_q;

  logic [2*DIR_W-1:0]      dir_mem [BEAMS];
  logic [DIST_W-1:0]       dist_mem [BEAMS];
  logic [2*DIR_W-1:0]      dir_rd_q;
  logic [DIST_W-1:0]       dist_rd_q;
  logic                    vld_rd_q;

  logic                    accept, in_ok, idx_ok, edge_start, in_edge;
  op_e                     op;
  logic [IDX_W-1:0]        in_idx, rd_addr;
  logic [CNT_W-1:0]        n_sel;
  logic [DIST_W-1:0]       old_dist, best_nx, wr_dist;
  logic signed [CRD_W-1:0] p1x, p1y, p2x, p2y;
  edge_res_t               eres;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);
  assign in_idx          = s_axis_tdata_i[IDX_W-1:0];

  always_comb begin
    in_ok    = int'(in_idx) < BEAMS;
    idx_ok   = int'(idx_q) < BEAMS;
    n_sel    = (int'(bcnt_q) > BEAMS) ? CNT_W'(BEAMS) : CNT_W'(bcnt_q);
    rd_addr  = (state_q == ST_IDLE) ? in_idx : beam_q[IDX_W-1:0];
    old_dist = vld_rd_q ? dist_rd_q : fill_q;
    best_nx  = (eres.hit && eres.span < best_q) ? eres.span : best_q;
    wr_dist  = (best_q < old_dist) ? best_q : old_dist;
    in_edge  = state_q == ST_EDGE;
    // the corner ring rotates at each finished edge, so the next edge sits one tap on
    p1x      = in_edge ? cx_q[1] : cx_q[0];
    p1y      = in_edge ? cy_q[1] : cy_q[0];
    p2x      = in_edge ? cx_q[2] : cx_q[1];
    p2y      = in_edge ? cy_q[2] : cy_q[1];
    edge_start = (state_q == ST_BLAT) || (in_edge && eres.done && j_q != 2'd3);
  end

  rbfd_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (edge_start),
    .dir_x_i ($signed(dir_rd_q[2*DIR_W-1:DIR_W])),
    .dir_y_i ($signed(dir_rd_q[DIR_W-1:0])),
    .p1_x_i  (p1x),
    .p1_y_i  (p1y),
    .p2_x_i  (p2x),
    .p2_y_i  (p2y),
    .eps_i   (eps_q),
    .res_o   (eres)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_DIST_RST;
      eps_q  <= DET_EPS_RST;
      bcnt_q <= BEAM_CNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_DIST: max_q  <= cfg_data_i[DIST_W-1:0];
        CFG_DET_EPS:  eps_q  <= cfg_data_i[EPS_W-1:0];
        CFG_BEAM_CNT: bcnt_q <= cfg_data_i[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: beam loop, edge loop, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      beam_q    <= '0;
      n_q       <= '0;
      j_q       <= '0;
      vld_q     <= '0;
      fill_q    <= MAX_DIST_RST;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_CLEAR: begin
                // drop every stored distance back to the current ceiling
                vld_q  <= '0;
                fill_q <= max_q;
              end
              OP_LOAD: ;
              OP_RECT: begin
                beam_q <= '0;
                n_q    <= n_sel;
                if (n_sel != '0) state_q <= ST_BRD;
              end
              OP_READ: state_q <= ST_READ;
              default: ;
            endcase
          end
        end
        ST_READ: begin
          m_valid_q <= 1'b1;
          state_q   <= ST_IDLE;
        end
        ST_BRD:  state_q <= ST_BLAT;
        ST_BLAT: begin
          j_q     <= '0;
          state_q <= ST_EDGE;
        end
        ST_EDGE: begin
          if (eres.done) begin
            j_q <= j_q + 2'd1;
            if (j_q == 2'd3) state_q <= ST_BWR;
          end
        end
        ST_BWR: begin
          vld_q[beam_q[IDX_W-1:0]] <= 1'b1;
          beam_q <= beam_q + CNT_W'(1);
          state_q <= (beam_q + CNT_W'(1) == n_q) ? ST_IDLE : ST_BRD;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload: corners, running minimum, result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= in_idx;
      for (int k = 0; k < 4; k++) begin
        cx_q[k] <= $signed(s_axis_tdata_i[CRN_LO + 2*k*CRD_W +: CRD_W]);
        cy_q[k] <= $signed(s_axis_tdata_i[CRN_LO + (2*k+1)*CRD_W +: CRD_W]);
      end
    end else if (in_edge && eres.done) begin
      cx_q[0] <= cx_q[1];
      cx_q[1] <= cx_q[2];
      cx_q[2] <= cx_q[3];
      cx_q[3] <= cx_q[0];
      cy_q[0] <= cy_q[1];
      cy_q[1] <= cy_q[2];
      cy_q[2] <= cy_q[3];
      cy_q[3] <= cy_q[0];
    end
    if (state_q == ST_BLAT) begin
      best_q <= max_q;
    end else if (in_edge && eres.done) begin
      best_q <= best_nx;
    end
    if (state_q == ST_READ) begin
      out_idx_q  <= idx_q;
      out_dist_q <= idx_ok ? old_dist : '0;
    end
  end

  // direction table
  always_ff @(posedge clk_i) begin
    if (accept && op == OP_LOAD && in_ok) begin
      dir_mem[in_idx] <= {s_axis_tdata_i[DIR_X_LO +: DIR_W], s_axis_tdata_i[DIR_Y_LO +: DIR_W]};
    end
    dir_rd_q <= dir_mem[rd_addr];
  end

  // distance table, entries without a valid bit read as the fill value
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BWR) begin
      dist_mem[beam_q[IDX_W-1:0]] <= wr_dist;
    end
    dist_rd_q <= dist_mem[rd_addr];
    vld_rd_q  <= vld_q[rd_addr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, out_dist_q, out_idx_q};

endmodule

FILE: rtl/core/rbfd_chk.sv
// Port-level checker of the free-distance scanner, bound to the top level.
// Depends on rbfd_pkg and ray_box_free_distance.
module rbfd_chk import rbfd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [IN_W-1:0]      s_axis_tdata_i,
  input logic [1:0]           s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OUT_W-1:0]     m_axis_tdata_o
);

  logic acc;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser_i != OP_READ |=> !m_axis_tvalid_o)
    else $error("result shown for an op without one");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser_i == OP_READ |=> !s_axis_tready_o)
    else $error("transfer taken while a read is in flight");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser_i == OP_READ |-> ##2
      (m_axis_tvalid_o && m_axis_tdata_o[IDX_W-1:0] == $past(s_axis_tdata_i[IDX_W-1:0], 2)))
    else $error("read result missing or for the wrong beam");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind ray_box_free_distance rbfd_chk u_rbfd_chk (.*);

FILE: bench/ray_box_free_distance_tb.sv
// Self-checking bench for the ray/box free-distance scanner: directed and random
// transfers against an in-bench predictor of the beam tables. Depends on rbfd_pkg
// and on the ray_box_free_distance top level only.
module ray_box_free_distance_tb;
  import rbfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RECT_CYCLES = 200;                     // per active beam, with margin
  localparam int UNIT = 65536;                          // 1.0 in Q16.16

  typedef struct {
    op_e         op;
    logic [5:0]  beam;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [31:0] cx[4];
    logic [31:0] cy[4];
  } scan_item_t;

  typedef struct {
    logic [5:0]        beam;
    logic [DIST_W-1:0] free_dist;
  } beam_dist_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i;
  logic [1:0]        s_axis_tuser_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  ray_box_free_distance uut (.*);

  // Predictor state: configuration and both beam tables
  logic [DIST_W-1:0] max_dist_q;
  logic [EPS_W-1:0]  det_eps_q;
  logic [BCNT_W-1:0] beam_cnt_q;
  logic [31:0]       dir_tab[BEAMS];
  logic [DIST_W-1:0] free_tab[BEAMS];

  beam_dist_t pending_reads[$];
  int         fail_count;
  int         cycle_count;
  int         burst_left;
  bit         gaps_on;
  bit         valid_up;
  int         hold_left;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stretches of free flow alternate with random stalls; a long
  // hold-off can be requested to back the block up into its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (cycle_count[6]) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) < 65);
    end
  end

  // Result checker: sample on the falling edge, when the transfer at the next
  // rising edge is already decided.
  always @(negedge clk_i) begin
    beam_dist_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reads.size() == 0) begin
        $display("%t unexpected result: beam %0d distance %0d", $realtime,
                 m_axis_tdata_o[5:0], m_axis_tdata_o[36:6]);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tdata_o[5:0] !== want.beam) begin
          $display("%t read_index: expected %0d actual %0d", $realtime, want.beam,
                   m_axis_tdata_o[5:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[36:6] !== want.free_dist) begin
          $display("%t free_distance (beam %0d): expected %0d actual %0d", $realtime,
                   want.beam, want.free_dist, m_axis_tdata_o[36:6]);
          fail_count++;
        end
      end
    end
  end

  // One edge test in exact integer terms; products wrap at 64 bits.
  function automatic bit edge_hit(longint dx, longint dy, longint p1x, longint p1y,
                                  longint p2x, longint p2y, output logic [DIST_W-1:0] len);
    longint      ex, ey, det, n2, a, b;
    bit          dneg, nneg;
    logic [63:0] d, mag, q, r;
    ex = p2x - p1x;
    ey = p2y - p1y;
    det = dy * ex - dx * ey;
    n2 = dx * p1y - dy * p1x;
    a = ex * p1y;
    b = ey * p1x;
    dneg = det < 0;
    d = dneg ? -det : det;
    len = '0;
    if (d == 0 || d < 64'(det_eps_q)) return 1'b0;
    if (dneg) n2 = -n2;
    if (n2 < 0 || longint'(n2) > longint'(d)) return 1'b0;
    nneg = !(a >= b);
    mag = nneg ? (b - a) : (a - b);
    if (mag != 0 && nneg != dneg) return 1'b0;
    if (d < (64'd1 << 47) && mag >= (d << 17)) begin
      len = DIST_SAT;
      return 1'b1;
    end
    q = mag / d;
    r = mag % d;
    for (int i = 0; i < FRAC_SH; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    len = (q > 64'(DIST_SAT)) ? DIST_SAT : q[DIST_W-1:0];
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted transfer
  task automatic predict_scan(scan_item_t it);
    int                n;
    longint            dx, dy;
    logic [DIST_W-1:0] best, hit_len;
    beam_dist_t        rd;
    case (it.op)
      OP_CLEAR: for (int i = 0; i < BEAMS; i++) free_tab[i] = max_dist_q;
      OP_LOAD:  dir_tab[it.beam] = {it.dir_x, it.dir_y};
      OP_RECT: begin
        n = (beam_cnt_q < BEAMS) ? beam_cnt_q : BEAMS;
        for (int i = 0; i < n; i++) begin
          dx = longint'($signed(dir_tab[i][31:16]));
          dy = longint'($signed(dir_tab[i][15:0]));
          best = max_dist_q;
          for (int j = 0; j < 4; j++) begin
            if (edge_hit(dx, dy, longint'($signed(it.cx[j])), longint'($signed(it.cy[j])),
                         longint'($signed(it.cx[(j+1)%4])), longint'($signed(it.cy[(j+1)%4])),
                         hit_len) && hit_len < best)
              best = hit_len;
          end
          if (best < free_tab[i]) free_tab[i] = best;
        end
      end
      default: begin
        rd.beam = it.beam;
        rd.free_dist = free_tab[it.beam];
        pending_reads = {pending_reads, rd};
      end
    endcase
  endtask

  // Offer one item, hold it until the transfer, then maybe open a gap
  task automatic send_item(scan_item_t it);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.op;
    s_axis_tdata_i  <= {2'b00, it.cy[3], it.cx[3], it.cy[2], it.cx[2], it.cy[1], it.cx[1],
                        it.cy[0], it.cx[0], it.dir_y, it.dir_x, it.beam};
    valid_up = 1'b1;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    predict_scan(it);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_axis_tvalid_i <= 1'b0;
        valid_up = 1'b0;
        gap = $urandom_range(6, 1);
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(8, 1);
      end
    end
  endtask

  // Drop valid right at the edge of the last transfer of a sequence
  task automatic release_bus();
    if (valid_up) begin
      s_axis_tvalid_i <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // Wait until every read has returned and any rectangle scan has run out
  task automatic drain();
    int n;
    release_bus();
    while (pending_reads.size() != 0) @(posedge clk_i);
    n = (beam_cnt_q < BEAMS) ? beam_cnt_q : BEAMS;
    repeat (RECT_CYCLES * n + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_DIST: max_dist_q = val;
      CFG_DET_EPS:  det_eps_q  = val[EPS_W-1:0];
      CFG_BEAM_CNT: beam_cnt_q = val[BCNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic scan_item_t blank_item(op_e op, logic [5:0] beam);
    scan_item_t it;
    it.op = op;
    it.beam = beam;
    it.dir_x = '0;
    it.dir_y = '0;
    for (int j = 0; j < 4; j++) begin
      it.cx[j] = '0;
      it.cy[j] = '0;
    end
    return it;
  endfunction

  task automatic send_read(logic [5:0] beam);
    send_item(blank_item(OP_READ, beam));
  endtask

  task automatic send_load(logic [5:0] beam, int dx, int dy);
    scan_item_t it;
    it = blank_item(OP_LOAD, beam);
    it.dir_x = 16'(dx);
    it.dir_y = 16'(dy);
    send_item(it);
  endtask

  // Axis-aligned box from x0..x1, y0..y1, corners in loop order
  task automatic send_box(int x0, int y0, int x1, int y1);
    scan_item_t it;
    it = blank_item(OP_RECT, 6'(0));
    it.cx[0] = x0; it.cy[0] = y0;
    it.cx[1] = x1; it.cy[1] = y0;
    it.cx[2] = x1; it.cy[2] = y1;
    it.cx[3] = x0; it.cy[3] = y1;
    send_item(it);
  endtask

  // Directions spread over the full circle, at unity scale
  task automatic load_beam_fan();
    real ang;
    for (int i = 0; i < BEAMS; i++) begin
      ang = 6.283185307179586 * i / BEAMS;
      send_load(6'(i), $rtoi($cos(ang) * 16384.0), $rtoi($sin(ang) * 16384.0));
    end
  endtask

  task automatic test_reset_values();
    send_read(6'd0);
    send_read(6'd63);
    load_beam_fan();
    send_read(6'd17);
    drain();
  endtask

  task automatic test_directed_boxes();
    scan_item_t it;
    send_load(6'd0, 16384, 0);
    send_load(6'd16, 0, 16384);
    send_load(6'd32, -16384, 0);
    send_load(6'd48, 0, -16384);
    send_box(5 * UNIT, -UNIT, 8 * UNIT, UNIT);           // only beams near zero degrees
    send_read(6'd0);
    send_read(6'd32);
    send_box(-2 * UNIT, -2 * UNIT, 2 * UNIT, 2 * UNIT);  // origin inside: every beam hits
    send_read(6'd16);
    send_read(6'd48);
    send_box(3 * UNIT, 3 * UNIT, 3 * UNIT, 3 * UNIT);    // degenerate: zero determinant
    it = blank_item(OP_RECT, 6'd0);                      // corners at the extremes
    it.cx[0] = 32'h8000_0000; it.cy[0] = 32'h7FFF_FFFF;
    it.cx[1] = 32'h7FFF_FFFF; it.cy[1] = 32'h7FFF_FFFF;
    it.cx[2] = 32'h7FFF_FFFF; it.cy[2] = 32'h8000_0000;
    it.cx[3] = 32'h8000_0000; it.cy[3] = 32'h8000_0000;
    send_item(it);
    send_read(6'd8);
    send_item(blank_item(OP_CLEAR, 6'd0));
    send_read(6'd0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_DET_EPS, 0);                // zero determinant must still be parallel
    write_reg(CFG_BEAM_CNT, 2);
    send_box(UNIT, UNIT, UNIT, UNIT);
    send_box(UNIT / 2, -UNIT, UNIT / 2 + 1, UNIT);     // very close thin edge
    send_read(6'd0);
    write_reg(CFG_DET_EPS, 16'hFFFF);         // nearly everything parallel
    send_box(-UNIT, -UNIT, UNIT, UNIT);
    send_read(6'd1);
    write_reg(CFG_MAX_DIST, 0);
    send_item(blank_item(OP_CLEAR, 6'd0));
    send_read(6'd5);
    write_reg(CFG_MAX_DIST, DIST_SAT);
    send_item(blank_item(OP_CLEAR, 6'd0));
    write_reg(CFG_DET_EPS, 1);
    write_reg(CFG_BEAM_CNT, 0);               // scans nothing
    send_box(-UNIT, -UNIT, UNIT, UNIT);
    send_read(6'd0);
    write_reg(CFG_BEAM_CNT, 127);             // clamps to the table size
    send_box(-30000 * UNIT, -30000 * UNIT, 30000 * UNIT, 30000 * UNIT);
    send_read(6'd63);
    send_read(6'd12);
    write_reg(CFG_UNUSED, 31'h7FFF_FFFF);     // no register: ignore
    send_read(6'd40);
    drain();
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(9) == 0) return $urandom();
    return 32'($signed($urandom_range(80 * UNIT)) - 40 * UNIT);
  endfunction

  task automatic send_random_item();
    scan_item_t it;
    int sel, cx, cy, hx, hy, sx, sy;
    sel = $urandom_range(99);
    it = blank_item(OP_READ, 6'($urandom_range(63)));
    if (sel < 5) begin
      it.op = OP_CLEAR;
    end else if (sel < 25) begin
      it.op = OP_LOAD;
      if ($urandom_range(1)) begin
        sx = $urandom_range(16384);
        sy = $rtoi($sqrt(268435456.0 - real'(sx) * sx));
        it.dir_x = 16'($urandom_range(1) ? -sx : sx);
        it.dir_y = 16'($urandom_range(1) ? -sy : sy);
      end else begin
        it.dir_x = 16'(int'($urandom_range(32768)) - 16384);
        it.dir_y = 16'(int'($urandom_range(32768)) - 16384);
      end
    end else if (sel < 50) begin
      it.op = OP_RECT;
      if ($urandom_range(4) == 0) begin
        for (int j = 0; j < 4; j++) begin
          it.cx[j] = rand_coord();
          it.cy[j] = rand_coord();
        end
      end else begin
        // Well-formed box, sometimes turned by swapping the winding
        cx = int'($urandom_range(40 * UNIT)) - 20 * UNIT;
        cy = int'($urandom_range(40 * UNIT)) - 20 * UNIT;
        hx = $urandom_range(8 * UNIT, UNIT / 8);
        hy = $urandom_range(8 * UNIT, UNIT / 8);
        it.cx[0] = cx - hx; it.cy[0] = cy - hy;
        it.cx[1] = cx + hx; it.cy[1] = cy - hy;
        it.cx[2] = cx + hx; it.cy[2] = cy + hy;
        it.cx[3] = cx - hx; it.cy[3] = cy + hy;
        if ($urandom_range(1)) begin
          it.cx[1] = cx - hx; it.cy[1] = cy + hy;
          it.cx[3] = cx + hx; it.cy[3] = cy - hy;
        end
      end
    end
    send_item(it);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_BEAM_CNT, $urandom_range(12, 1));
      write_reg(CFG_DET_EPS, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(2000));
      write_reg(CFG_MAX_DIST, $urandom_range(1) ? $urandom() : $urandom_range(60 * UNIT));
      gaps_on = (ph != 2);                    // one phase runs back to back
      for (int i = 0; i < 8; i++) send_random_item();
    end
    drain();
  endtask

  // Hold the receiver off while reads keep coming, so the block backs up
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_left <= 400;
    for (int i = 0; i < 16; i++) send_read(6'($urandom_range(63)));
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = OP_CLEAR;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_DIST;
    cfg_data_i = '0;
    fail_count = 0;
    cycle_count = 0;
    hold_left = 0;
    valid_up = 1'b0;
    gaps_on = 1'b1;
    burst_left = $urandom_range(8, 1);
    max_dist_q = MAX_DIST_RST;
    det_eps_q = DET_EPS_RST;
    beam_cnt_q = BEAM_CNT_RST;
    for (int i = 0; i < BEAMS; i++) begin
      dir_tab[i] = '0;
      free_tab[i] = MAX_DIST_RST;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_boxes();
    test_register_extremes();
    test_output_backpressure();
    test_random_phases();

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
